>>> hdl/least_squares_line_fit_macros.svh
// Assertion macros shared by the line-fit block
`ifndef LEAST_SQUARES_LINE_FIT_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LSF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsf: implication check failed");
// next-cycle implication
`define LSF_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsf: next-cycle check failed");
`else
`define LSF_ASSERT_IMP(lbl, ante, cons)
`define LSF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/lsf_pkg.sv
package lsf_pkg;

   // run length and derived counter widths
   localparam int MAX_POINTS = 4096;
   localparam int CNT_W      = $clog2(MAX_POINTS) + 1;

   // field widths
   localparam int IDX_W  = 16;
   localparam int X_W    = IDX_W + 1;
   localparam int X2_W   = 2 * X_W;
   localparam int Y_W    = 32;
   localparam int XY_W   = X_W + 1 + Y_W;
   localparam int OUT_W  = 48;

   // accumulator widths
   localparam int SX_W   = 29;
   localparam int SX2_W  = 45;
   localparam int SY_W   = 44;
   localparam int SXY_W  = 62;

   // back-end arithmetic widths
   localparam int DEN_W     = 58;
   localparam int NUM_W     = 96;
   localparam int MULT_W    = SX2_W;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   // job queue
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QLVL_W = $clog2(QDEPTH + 1);

   // saturation limits
   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic signed [Y_W-1:0] sample;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] slope;
      logic signed [OUT_W-1:0] intercept;
      logic                    degenerate;
   } rsp_type;

   // one finished run handed from the accumulator to the solver
   typedef struct packed {
      logic [CNT_W-1:0]        n;
      logic [SX_W-1:0]         sum_x;
      logic [SX2_W-1:0]        sum_x2;
      logic signed [SY_W-1:0]  sum_y;
      logic signed [SXY_W-1:0] sum_xy;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_MUL,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_ROUND,
      DV_SAT
   } div_state_type;

   // product terms, in order: D, slope numerator, intercept numerator
   typedef enum logic [2:0] {
      MS_N_SX2,
      MS_SX_SX,
      MS_N_SXY,
      MS_SX_SY,
      MS_SX2_SY,
      MS_SX_SXY
   } mac_step_type;

endpackage

>>> hdl/lsf_front.sv
module lsf_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  lsf_pkg::req_type             req_item,
   input  logic                         csr_we,
   input  logic [lsf_pkg::IDX_W-1:0]    csr_wdata,
   input  logic [lsf_pkg::QLVL_W-1:0]   q_level,
   output logic                         push,
   output lsf_pkg::job_type             push_job
);
   import lsf_pkg::*;

   logic [IDX_W-1:0]        start_index_ff;
   logic [CNT_W-1:0]        count_ff, count_in;

   logic                    s1_valid_ff, s1_use_ff, s1_last_ff;
   logic [CNT_W-1:0]        s1_n_ff;
   logic [X_W-1:0]          s1_x_ff;
   logic [X2_W-1:0]         s1_x2_ff;
   logic signed [Y_W-1:0]   s1_y_ff;
   logic signed [XY_W-1:0]  s1_xy_ff;

   logic [SX_W-1:0]         sum_x_ff, sum_x_in, nsum_x;
   logic [SX2_W-1:0]        sum_x2_ff, sum_x2_in, nsum_x2;
   logic signed [SY_W-1:0]  sum_y_ff, sum_y_in, nsum_y;
   logic signed [SXY_W-1:0] sum_xy_ff, sum_xy_in, nsum_xy;

   logic                    accept, use_pt;
   logic [X_W-1:0]          x_val;
   logic [CNT_W-1:0]        n_next;
   logic [QLVL_W:0]         occupancy;

   // stall while every queue slot is taken or claimed by a run in flight
   assign occupancy = {1'b0, q_level} + (QLVL_W+1)'(s1_valid_ff & s1_last_ff);
   assign busy      = occupancy >= (QLVL_W+1)'(QDEPTH);
   assign accept    = start & ~busy;

   // position of this item; items past the limit are dropped
   assign use_pt   = count_ff < CNT_W'(MAX_POINTS);
   assign x_val    = X_W'(start_index_ff) + X_W'(count_ff[CNT_W-2:0]);
   assign n_next   = count_ff + CNT_W'(use_pt);
   assign count_in = accept ? (req_item.last ? '0 : n_next) : count_ff;

   // configuration and point counter
   always_ff @(posedge clock) begin
      if (reset) begin
         start_index_ff <= '0;
         count_ff       <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            start_index_ff <= csr_wdata;
         end
         count_ff    <= count_in;
         s1_valid_ff <= accept;
      end
   end

   // stage 1: square and cross product
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_use_ff  <= use_pt;
         s1_last_ff <= req_item.last;
         s1_n_ff    <= n_next;
         s1_x_ff    <= x_val;
         s1_x2_ff   <= X2_W'(x_val) * X2_W'(x_val);
         s1_y_ff    <= req_item.sample;
         s1_xy_ff   <= XY_W'($signed({1'b0, x_val})) * XY_W'(req_item.sample);
      end
   end

   // stage 2: accumulate, hand the run over on the last item
   always_comb begin
      nsum_x  = sum_x_ff  + (s1_use_ff ? SX_W'(s1_x_ff)   : SX_W'(0));
      nsum_x2 = sum_x2_ff + (s1_use_ff ? SX2_W'(s1_x2_ff) : SX2_W'(0));
      nsum_y  = sum_y_ff  + (s1_use_ff ? SY_W'(s1_y_ff)   : SY_W'(0));
      nsum_xy = sum_xy_ff + (s1_use_ff ? SXY_W'(s1_xy_ff) : SXY_W'(0));
      sum_x_in  = sum_x_ff;
      sum_x2_in = sum_x2_ff;
      sum_y_in  = sum_y_ff;
      sum_xy_in = sum_xy_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            sum_x_in  = '0;
            sum_x2_in = '0;
            sum_y_in  = '0;
            sum_xy_in = '0;
         end else begin
            sum_x_in  = nsum_x;
            sum_x2_in = nsum_x2;
            sum_y_in  = nsum_y;
            sum_xy_in = nsum_xy;
         end
      end
   end

   assign push            = s1_valid_ff & s1_last_ff;
   assign push_job.n      = s1_n_ff;
   assign push_job.sum_x  = nsum_x;
   assign push_job.sum_x2 = nsum_x2;
   assign push_job.sum_y  = nsum_y;
   assign push_job.sum_xy = nsum_xy;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff  <= '0;
         sum_x2_ff <= '0;
         sum_y_ff  <= '0;
         sum_xy_ff <= '0;
      end else begin
         sum_x_ff  <= sum_x_in;
         sum_x2_ff <= sum_x2_in;
         sum_y_ff  <= sum_y_in;
         sum_xy_ff <= sum_xy_in;
      end
   end

endmodule

>>> hdl/lsf_queue.sv
module lsf_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  lsf_pkg::job_type           push_job,
   input  logic                       pop,
   output lsf_pkg::job_type           pop_job,
   output logic                       empty,
   output logic [lsf_pkg::QLVL_W-1:0] level
);
   import lsf_pkg::*;

   job_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QLVL_W-1:0]   level_ff;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         level_ff <= level_ff + QLVL_W'(push) - QLVL_W'(pop);
      end
   end

   assign pop_job = mem_ff[rd_ptr_ff];
   assign empty   = (level_ff == '0);
   assign level   = level_ff;

endmodule

>>> hdl/lsf_div.sv
module lsf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [lsf_pkg::NUM_W-1:0]  num,
   input  logic [lsf_pkg::DEN_W-1:0]         den,
   output logic                              done,
   output logic signed [lsf_pkg::OUT_W-1:0]  quot
);
   import lsf_pkg::*;

   div_state_type          state_ff, state_in;
   logic                   neg_ff, neg_in;
   logic [NUM_W-1:0]       dq_ff, dq_in;
   logic [DEN_W-1:0]       rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W:0]         qr_ff, qr_in;

   logic [DEN_W:0]         rem_sh;
   logic                   ge, round_up;

   // one restoring step: dividend bits shift out the top, quotient bits in below
   assign rem_sh   = {rem_ff, dq_ff[NUM_W-1]};
   assign ge       = rem_sh >= {1'b0, den};
   assign round_up = {rem_ff, 1'b0} >= {1'b0, den};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      qr_ff  <= qr_in;
   end

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      qr_in    = qr_ff;
      done     = 1'b0;
      quot     = '0;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               neg_in   = num[NUM_W-1];
               dq_in    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
               rem_in   = '0;
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            dq_in  = {dq_ff[NUM_W-2:0], ge};
            rem_in = ge ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               state_in = DV_ROUND;
            end
         end
         DV_ROUND: begin
            // half away from zero on the magnitude
            qr_in    = {1'b0, dq_ff} + (NUM_W+1)'(round_up);
            state_in = DV_SAT;
         end
         DV_SAT: begin
            done = 1'b1;
            if (!neg_ff) begin
               quot = (qr_ff > (NUM_W+1)'(OUT_MAX)) ? OUT_MAX : qr_ff[OUT_W-1:0];
            end else begin
               quot = (qr_ff > (NUM_W+1)'(OUT_MIN)) ? OUT_MIN
                                                    : ~qr_ff[OUT_W-1:0] + OUT_W'(1);
            end
            state_in = DV_IDLE;
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/lsf_back.sv
module lsf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  lsf_pkg::job_type  job,
   output logic              pop,
   output logic              rsp_valid,
   output lsf_pkg::rsp_type  rsp_item
);
   import lsf_pkg::*;

   back_state_type          state_ff, state_in;
   mac_step_type            step_ff, step_in;
   job_type                 job_ff, job_in;
   logic [NUM_W-1:0]        acc_ff, acc_in;
   logic [NUM_W-1:0]        mcand_ff, mcand_in;
   logic [MULT_W-1:0]       mult_ff, mult_in;
   logic                    sub_ff, sub_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic signed [OUT_W-1:0] slope_ff, slope_in;
   logic signed [OUT_W-1:0] intercept_ff, intercept_in;
   logic                    degen_ff, degen_in;

   logic [MULT_W-1:0]       mult_sel;
   logic [NUM_W-1:0]        mcand_sel;
   logic                    sub_sel, first_sel;
   logic [NUM_W-1:0]        mac_sum;
   logic                    div_start, div_done;
   logic signed [OUT_W-1:0] div_quot;

   lsf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ($signed(acc_ff)),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // operands of each product term; the unsigned factor drives the shift-add
   always_comb begin
      mult_sel  = '0;
      mcand_sel = '0;
      sub_sel   = 1'b0;
      first_sel = 1'b0;
      unique case (step_ff)
         MS_N_SX2: begin
            mult_sel  = MULT_W'(job_ff.n);
            mcand_sel = NUM_W'(job_ff.sum_x2);
            first_sel = 1'b1;
         end
         MS_SX_SX: begin
            mult_sel  = MULT_W'(job_ff.sum_x);
            mcand_sel = NUM_W'(job_ff.sum_x);
            sub_sel   = 1'b1;
         end
         MS_N_SXY: begin
            mult_sel  = MULT_W'(job_ff.n);
            mcand_sel = NUM_W'($signed(job_ff.sum_xy));
            first_sel = 1'b1;
         end
         MS_SX_SY: begin
            mult_sel  = MULT_W'(job_ff.sum_x);
            mcand_sel = NUM_W'($signed(job_ff.sum_y));
            sub_sel   = 1'b1;
         end
         MS_SX2_SY: begin
            mult_sel  = MULT_W'(job_ff.sum_x2);
            mcand_sel = NUM_W'($signed(job_ff.sum_y));
            first_sel = 1'b1;
         end
         MS_SX_SXY: begin
            mult_sel  = MULT_W'(job_ff.sum_x);
            mcand_sel = NUM_W'($signed(job_ff.sum_xy));
            sub_sel   = 1'b1;
         end
         default: begin
            mult_sel  = '0;
         end
      endcase
   end

   assign mac_sum = sub_ff ? acc_ff - mcand_ff : acc_ff + mcand_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff      <= step_in;
      job_ff       <= job_in;
      acc_ff       <= acc_in;
      mcand_ff     <= mcand_in;
      mult_ff      <= mult_in;
      sub_ff       <= sub_in;
      den_ff       <= den_in;
      slope_ff     <= slope_in;
      intercept_ff <= intercept_in;
      degen_ff     <= degen_in;
   end

   // sequencer: D, then slope, then intercept; a zero D emits a degenerate result
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      job_in       = job_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mult_in      = mult_ff;
      sub_in       = sub_ff;
      den_in       = den_ff;
      slope_in     = slope_ff;
      intercept_in = intercept_ff;
      degen_in     = degen_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               job_in   = job;
               step_in  = MS_N_SX2;
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            mult_in  = mult_sel;
            mcand_in = mcand_sel;
            sub_in   = sub_sel;
            if (first_sel) begin
               acc_in = '0;
            end
            state_in = BK_MUL;
         end
         BK_MUL: begin
            if (mult_ff != '0) begin
               if (mult_ff[0]) begin
                  acc_in = mac_sum;
               end
               mult_in  = mult_ff >> 1;
               mcand_in = mcand_ff << 1;
            end else begin
               unique case (step_ff)
                  MS_N_SX2: begin
                     step_in  = MS_SX_SX;
                     state_in = BK_LOAD;
                  end
                  MS_SX_SX: begin
                     den_in = acc_ff[DEN_W-1:0];
                     if (acc_ff[DEN_W-1:0] == '0) begin
                        // fewer than two distinct points
                        degen_in     = 1'b1;
                        slope_in     = '0;
                        intercept_in = '0;
                        state_in     = BK_EMIT;
                     end else begin
                        degen_in = 1'b0;
                        step_in  = MS_N_SXY;
                        state_in = BK_LOAD;
                     end
                  end
                  MS_N_SXY: begin
                     step_in  = MS_SX_SY;
                     state_in = BK_LOAD;
                  end
                  MS_SX2_SY: begin
                     step_in  = MS_SX_SXY;
                     state_in = BK_LOAD;
                  end
                  MS_SX_SY, MS_SX_SXY: begin
                     div_start = 1'b1;
                     state_in  = BK_DIV;
                  end
                  default: begin
                     state_in = BK_IDLE;
                  end
               endcase
            end
         end
         BK_DIV: begin
            if (div_done) begin
               if (step_ff == MS_SX_SY) begin
                  slope_in = div_quot;
                  step_in  = MS_SX2_SY;
                  state_in = BK_LOAD;
               end else begin
                  intercept_in = div_quot;
                  state_in     = BK_EMIT;
               end
            end
         end
         BK_EMIT: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_valid           = (state_ff == BK_EMIT);
   assign rsp_item.slope      = slope_ff;
   assign rsp_item.intercept  = intercept_ff;
   assign rsp_item.degenerate = degen_ff;

endmodule

>>> hdl/least_squares_line_fit.sv
// Channel   Handshake            Payload
// request   start / busy         req_item   (sample, last)
// result    rsp_valid            rsp_item   (slope, intercept, degenerate)
// config    csr_we               csr_wdata  (start_index)
//
// Items are taken at one per cycle while busy is low; each runs through a
// two-stage multiply/accumulate front end. A last item hands the run's sums to
// a two-entry job queue. The solver works on one job at a time: six shift-add
// products and two 96-step divisions. busy rises while both queue slots are
// held or claimed by a last item in flight. Reset is synchronous and needs no
// clearing pass. Results show for one cycle on rsp_valid and cannot be held
// off.
`include "least_squares_line_fit_macros.svh"

module least_squares_line_fit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lsf_pkg::req_type           req_item,
   output logic                       rsp_valid,
   output lsf_pkg::rsp_type           rsp_item,
   input  logic                       csr_we,
   input  logic [lsf_pkg::IDX_W-1:0]  csr_wdata
);
   import lsf_pkg::*;

   logic              push, pop, q_empty;
   job_type           push_job, pop_job;
   logic [QLVL_W-1:0] q_level;

   // accumulator front end
   lsf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_level   (q_level),
      .push      (push),
      .push_job  (push_job)
   );

   // finished runs waiting for the solver
   lsf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (q_empty),
      .level    (q_level)
   );

   // solver back end
   lsf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .job       (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // checks
   `LSF_ASSERT_NXT(a_single_strobe, rsp_valid, !rsp_valid)
   `LSF_ASSERT_IMP(a_degen_zero, rsp_valid && rsp_item.degenerate, rsp_item.slope == '0 && rsp_item.intercept == '0)
   `LSF_ASSERT_IMP(a_full_busy, q_level == QLVL_W'(QDEPTH), busy)
   `LSF_ASSERT_IMP(a_no_overflow, push, q_level != QLVL_W'(QDEPTH))

endmodule
